>>> hw/rtl/qfp_pkg.sv
// Package for the quadratic fit point generator.
// Holds the queue item and result types, the sequencer states and the point count.
// No dependencies.
package qfp_pkg;

  localparam int unsigned NumPoints = 40;
  localparam int unsigned Steps     = NumPoints - 1;
  localparam int unsigned KW        = $clog2(NumPoints + 1);
  localparam int unsigned IdxW      = 6;
  localparam int unsigned QDepth    = 2;
  // Quotient bits kept by the offset divider; anything larger saturates y anyway.
  localparam int unsigned QuoW      = 35;
  // Reciprocal of the step count; exact floor division for every 16-bit dividend.
  localparam int unsigned RecipShift = 22;
  localparam int unsigned RecipSteps = (1 << RecipShift) / Steps + 1;

  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [16:0] h12;
    logic signed [16:0] h23;
    logic signed [16:0] h13;
    logic signed [16:0] dy12;
    logic signed [16:0] dy23;
    logic               degen;
  } qfp_item_t;

  typedef struct packed {
    logic [IdxW-1:0]    idx;
    logic signed [15:0] x;
    logic signed [31:0] y;
    logic               degen;
    logic               last;
  } qfp_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_QDIV,
    ST_QREM,
    ST_XSTEP,
    ST_NUM,
    ST_MULLO,
    ST_MULHI,
    ST_DIVINIT,
    ST_DIVCHK,
    ST_DIV,
    ST_EMIT,
    ST_DEGEN
  } qfp_state_e;

endpackage

>>> hw/rtl/qfp_front.sv
// Front end: accepts one transfer of three sample points and classifies it.
// Computes the abscissa and ordinate differences and the degenerate flag. Uses qfp_pkg.
module qfp_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [95:0]       s_axis_tdata,
  input  logic              q_full_i,
  output logic              q_push_o,
  output qfp_pkg::qfp_item_t q_item_o
);
  import qfp_pkg::*;

  logic signed [15:0] ax, ay, bx, by_val, cx, cy;

  assign ax     = s_axis_tdata[15:0];
  assign ay     = s_axis_tdata[31:16];
  assign bx     = s_axis_tdata[47:32];
  assign by_val = s_axis_tdata[63:48];
  assign cx     = s_axis_tdata[79:64];
  assign cy     = s_axis_tdata[95:80];

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_item_o.x1    = ax;
    q_item_o.y1    = ay;
    q_item_o.x2    = bx;
    q_item_o.h12   = 17'(bx) - 17'(ax);
    q_item_o.h23   = 17'(cx) - 17'(bx);
    q_item_o.h13   = 17'(cx) - 17'(ax);
    q_item_o.dy12  = 17'(by_val) - 17'(ay);
    q_item_o.dy23  = 17'(cy) - 17'(by_val);
    q_item_o.degen = (bx == ax) || (cx == bx) || (cx == ax);
  end
endmodule

>>> hw/rtl/qfp_fifo.sv
// Short queue between the front end and the point sequencer.
// Holds classified items. Uses qfp_pkg.
module qfp_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  qfp_pkg::qfp_item_t wdata_i,
  input  logic               pop_i,
  output qfp_pkg::qfp_item_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);
  import qfp_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  qfp_item_t mem_q [QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

>>> hw/rtl/qfp_back.sv
// Back end: fits the parabola and sweeps the output points, one at a time.
// Shared multipliers, a long divider for the Newton offset and an output register. Uses qfp_pkg.
module qfp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qfp_pkg::qfp_item_t item_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output qfp_pkg::qfp_res_t  res_o
);
  import qfp_pkg::*;

  qfp_state_e state_q, state_d;
  qfp_item_t  it_q;

  logic signed [33:0] pa_q, pb_q, p12_q;
  logic signed [34:0] curv_q;
  logic signed [50:0] den_q, base_q;
  logic        [49:0] d2_q;
  logic        [15:0] hq_q, hn_q;
  logic        [5:0]  hr_q, racc_q;
  logic        [15:0] qacc_q;
  logic        [KW-1:0] k_q;
  logic signed [15:0] x_q;
  logic signed [16:0] dx_q, xm2_q;
  logic signed [52:0] num_q;
  logic        [15:0] dxm_q;
  logic               neg_q;
  logic        [42:0] plo_q;
  logic        [41:0] phi_q;
  logic        [78:0] dd_q;
  logic        [49:0] rem_q;
  logic        [QuoW-1:0] quo_q;
  logic        [5:0]  cnt_q;
  logic               sat_q;
  logic               ov_q;
  qfp_res_t           ores_q;

  logic        out_free;
  logic        last_pt;
  logic [32:0] hq_prod;
  logic [15:0] hr_full;
  logic [52:0] nmag;
  logic [50:0] div_try;
  logic [50:0] div_sub;
  logic signed [36:0] off;
  logic signed [36:0] yv;
  logic signed [31:0] ysat;
  logic [6:0]  rsum;

  assign out_free    = !ov_q || res_ready_i;
  assign last_pt     = (k_q == KW'(NumPoints));
  assign res_valid_o = ov_q;
  assign res_o       = ores_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (!empty_i) state_d = item_i.degen ? ST_DEGEN : ST_SETUP1;
      ST_SETUP1:  state_d = ST_SETUP2;
      ST_SETUP2:  state_d = ST_QDIV;
      ST_QDIV:    state_d = ST_QREM;
      ST_QREM:    state_d = ST_XSTEP;
      ST_XSTEP:   state_d = ST_NUM;
      ST_NUM:     state_d = ST_MULLO;
      ST_MULLO:   state_d = ST_MULHI;
      ST_MULHI:   state_d = ST_DIVINIT;
      ST_DIVINIT: state_d = ST_DIVCHK;
      ST_DIVCHK:  state_d = (dd_q[78:35] >= d2_q) ? ST_EMIT : ST_DIV;
      ST_DIV:     if (cnt_q == '0) state_d = ST_EMIT;
      ST_EMIT:    if (out_free) state_d = last_pt ? ST_IDLE : ST_XSTEP;
      ST_DEGEN:   if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop_o = (state_q == ST_IDLE) && !empty_i;
  end

  // Datapath helpers.
  always_comb begin
    hq_prod = 33'(hn_q) * 33'(RecipSteps);
    hr_full = hn_q - hq_q * 16'(Steps);
    nmag    = num_q[52] ? 53'(-num_q) : num_q;
    div_try = {rem_q, dd_q[34]};
    div_sub = div_try - {1'b0, d2_q};
    rsum    = 7'(racc_q) + 7'(hr_q);
    off     = sat_q ? 37'sh8_0000_0000 : 37'($unsigned(quo_q));
    if (neg_q) off = -off;
    yv = (37'(it_q.y1) <<< 8) + off;
    if (yv > 37'sh0_7FFF_FFFF)       ysat = 32'sh7FFF_FFFF;
    else if (yv < -37'sh0_8000_0000) ysat = 32'sh8000_0000;
    else                             ysat = yv[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_EMIT || state_q == ST_DEGEN) && out_free) ov_q <= 1'b1;
      else if (res_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        it_q <= item_i;
      end
      ST_SETUP1: begin
        pa_q  <= it_q.dy23 * it_q.h12;
        pb_q  <= it_q.dy12 * it_q.h23;
        p12_q <= it_q.h12 * it_q.h23;
      end
      ST_SETUP2: begin
        curv_q <= 35'(pa_q) - 35'(pb_q);
        den_q  <= 51'(p12_q) * 51'(it_q.h13);
        base_q <= 51'(pb_q) * 51'(it_q.h13);
        hn_q   <= it_q.h13[16] ? 16'(-it_q.h13) : it_q.h13[15:0];
        hr_q   <= '0;
        hq_q   <= '0;
      end
      ST_QDIV: begin
        // Quotient of |h13| by the step count through the scaled reciprocal.
        hq_q   <= 16'(hq_prod >> RecipShift);
        d2_q   <= {den_q[50] ? 49'(-den_q) : den_q[48:0], 1'b0};
        qacc_q <= '0;
        racc_q <= 6'(Steps / 2);
        k_q    <= KW'(1);
      end
      ST_QREM: begin
        hr_q <= hr_full[5:0];
      end
      ST_XSTEP: begin
        if (it_q.h13[16]) begin
          x_q   <= 16'(17'(it_q.x1) - 17'(qacc_q));
          dx_q  <= -17'(qacc_q);
          xm2_q <= 17'(it_q.x1) - 17'(qacc_q) - 17'(it_q.x2);
        end else begin
          x_q   <= 16'(17'(it_q.x1) + 17'(qacc_q));
          dx_q  <= 17'(qacc_q);
          xm2_q <= 17'(it_q.x1) + 17'(qacc_q) - 17'(it_q.x2);
        end
      end
      ST_NUM: begin
        num_q <= 53'(base_q) + 53'(xm2_q) * 53'(curv_q);
        dxm_q <= dx_q[16] ? 16'(-dx_q) : dx_q[15:0];
      end
      ST_MULLO: begin
        neg_q <= (dx_q[16] ^ num_q[52]) ^ den_q[50];
        plo_q <= dxm_q * nmag[26:0];
      end
      ST_MULHI: begin
        phi_q <= dxm_q * nmag[52:27];
      end
      ST_DIVINIT: begin
        // Rounded quotient: (2*P + d) / (2*d) with P = |dx| * 256 * |num|.
        dd_q <= (((79'(phi_q) << 27) + 79'(plo_q)) << 9) + 79'(d2_q[49:1]);
      end
      ST_DIVCHK: begin
        sat_q <= (dd_q[78:35] >= d2_q);
        rem_q <= 50'(dd_q[78:35]);
        quo_q <= '0;
        cnt_q <= 6'(QuoW - 1);
      end
      ST_DIV: begin
        if (!div_sub[50]) begin
          rem_q <= div_sub[49:0];
          quo_q <= {quo_q[QuoW-2:0], 1'b1};
        end else begin
          rem_q <= div_try[49:0];
          quo_q <= {quo_q[QuoW-2:0], 1'b0};
        end
        dd_q  <= {dd_q[77:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          ores_q.idx   <= k_q[IdxW-1:0];
          ores_q.x     <= x_q;
          ores_q.y     <= ysat;
          ores_q.degen <= 1'b0;
          ores_q.last  <= last_pt;
          k_q          <= k_q + 1'b1;
          // Step the rounded abscissa offset by |h13| / steps, carrying the remainder.
          if (rsum >= 7'(Steps)) begin
            racc_q <= 6'(rsum - 7'(Steps));
            qacc_q <= qacc_q + hq_q + 16'd1;
          end else begin
            racc_q <= rsum[5:0];
            qacc_q <= qacc_q + hq_q;
          end
        end
      end
      ST_DEGEN: begin
        if (out_free) begin
          ores_q.idx   <= IdxW'(1);
          ores_q.x     <= it_q.x1;
          ores_q.y     <= '0;
          ores_q.degen <= 1'b1;
          ores_q.last  <= 1'b1;
        end
      end
      default: begin
        it_q <= it_q;
      end
    endcase
  end
endmodule

>>> hw/rtl/quadratic_fit_point_generator_top.sv
// Quadratic fit point generator: three Q8.8 samples in, forty fitted points out (x Q8.8, y Q16.16).
// Each point runs through a bit-serial offset divider, after a fit setup per item; a
// degenerate item skips the fit and gives a single point.
// A two-entry queue accepts new items while the sequencer works.
// Reset (rst_ni low, asynchronous) empties the queue and output register and idles the sequencer.
module quadratic_fit_point_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ax, ay, bx, by_val, cx, cy (16 bits each, lowest first)
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // point_index[5:0], point_x[21:6], point_y[53:22], zero fill[55:54]
  output logic [55:0] m_axis_tdata,
  // degenerate
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import qfp_pkg::*;

  qfp_item_t push_item, head_item;
  qfp_res_t  res;
  logic push, pop, full, empty;

  qfp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (full),
    .q_push_o      (push),
    .q_item_o      (push_item)
  );

  qfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (pop),
    .rdata_o (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  qfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.y, res.x, res.idx};
  assign m_axis_tuser = res.degen;
  assign m_axis_tlast = res.last;

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && empty))
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && full))
    else $error("queue pushed while full");
  a_degen_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[5:0] == 6'd1))
    else $error("degenerate result is not a single first point");
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> (m_axis_tdata[5:0] == IdxW'(NumPoints)))
    else $error("last point has wrong index");
endmodule

>>> verif/tb.sv
// Self-checking testbench for the quadratic fit point generator.
// Drives sample triples over the input stream and checks every fitted point against
// an internal exact-integer predictor. Depends on qfp_pkg and the top-level RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qfp_pkg::*;

  localparam int unsigned WatchdogLimit = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  qfp_res_t fit_points_q[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       err_count = 0;
  int       quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  quadratic_fit_point_generator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Rounded quotient, ties away from zero.
  function automatic longint div_round(longint n, longint d);
    longint m;
    longint dm;
    longint q;
    m  = n < 0 ? -n : n;
    dm = d < 0 ? -d : d;
    q  = (m + dm / 2) / dm;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // Rounded (dx*256*num/den) with magnitude clamped to 2^40.
  function automatic longint fit_offset(longint dx, longint num, longint den);
    logic [127:0] prod;
    logic [127:0] dmag;
    logic [127:0] quo;
    bit           neg;
    neg = ((dx < 0) != (num < 0)) != (den < 0);
    if (dx == 0 || num == 0) return 0;
    prod = 128'(dx < 0 ? -dx : dx) * 128'd256 * 128'(num < 0 ? -num : num);
    dmag = 128'(den < 0 ? -den : den);
    quo  = (2 * prod + dmag) / (2 * dmag);
    if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  task automatic predict_fit(logic [95:0] d);
    longint   x1, y1, x2, y2, x3, y3;
    longint   h12, h23, h13, dy12, dy23, den, curv, x, num, yv;
    qfp_res_t r;
    x1 = longint'($signed(d[15:0]));  y1 = longint'($signed(d[31:16]));
    x2 = longint'($signed(d[47:32])); y2 = longint'($signed(d[63:48]));
    x3 = longint'($signed(d[79:64])); y3 = longint'($signed(d[95:80]));
    h12 = x2 - x1; h23 = x3 - x2; h13 = x3 - x1;
    dy12 = y2 - y1; dy23 = y3 - y2;
    if (h12 == 0 || h23 == 0 || h13 == 0) begin
      r.idx = IdxW'(1); r.x = d[15:0]; r.y = '0; r.degen = 1'b1; r.last = 1'b1;
      fit_points_q.push_back(r);
      return;
    end
    den  = h12 * h23 * h13;
    curv = dy23 * h12 - dy12 * h23;
    for (int k = 1; k <= NumPoints; k++) begin
      x   = x1 + div_round(h13 * (k - 1), Steps);
      num = dy12 * h23 * h13 + (x - x2) * curv;
      yv  = y1 * 256 + fit_offset(x - x1, num, den);
      if (yv > 64'sd2147483647) yv = 64'sd2147483647;
      if (yv < -64'sd2147483648) yv = -64'sd2147483648;
      r.idx = IdxW'(k); r.x = 16'(x); r.y = 32'(yv);
      r.degen = 1'b0; r.last = (k == NumPoints);
      fit_points_q.push_back(r);
    end
  endtask

  // Leaves tvalid high after the transfer so back-to-back items need no extra edge.
  task automatic send_triple(logic [15:0] ax, ay, bx, by_val, cx, cy);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cy, cx, by_val, bx, ay, ax};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_fit({cy, cx, by_val, bx, ay, ax});
  endtask

  always @(posedge clk_i) begin
    if (recv_idle_pct == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    qfp_res_t got;
    qfp_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.idx = m_axis_tdata[5:0]; got.x = m_axis_tdata[21:6];
      got.y = m_axis_tdata[53:22]; got.degen = m_axis_tuser; got.last = m_axis_tlast;
      if (fit_points_q.size() == 0) begin
        $display("%t unexpected point: idx=%0d x=%0d y=%0d", $realtime, got.idx,
                 got.x, got.y);
        err_count++;
      end else begin
        want = fit_points_q.pop_front();
        if (got !== want) begin
          $display("%t mismatch: expected idx=%0d x=%0d y=%0d degen=%b last=%b",
                   $realtime, want.idx, want.x, want.y, want.degen, want.last);
          $display("%t           actual   idx=%0d x=%0d y=%0d degen=%b last=%b",
                   $realtime, got.idx, got.x, got.y, got.degen, got.last);
          err_count++;
        end
      end
    end
  end

  // Ends the run if neither stream moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_degenerate();
    send_triple(16'h0100, 16'h0200, 16'h0100, 16'h0300, 16'h0500, 16'h0000);
    send_triple(16'h0000, 16'h7fff, 16'h0300, 16'h8000, 16'h0300, 16'h1234);
    send_triple(16'h8000, 16'h0001, 16'h0040, 16'h0002, 16'h8000, 16'hffff);
    send_triple(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
  endtask

  task automatic test_extremes();
    send_triple(16'h8000, 16'h8000, 16'h0000, 16'h7fff, 16'h7fff, 16'h8000);
    send_triple(16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff, 16'h7fff);
    // Tight spacing next to a far end point drives huge curvature and saturation.
    send_triple(16'h0000, 16'h8000, 16'h0001, 16'h7fff, 16'h7fff, 16'h8000);
    send_triple(16'h7ffe, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_triple(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0002, 16'h0000);
    send_triple(16'hffff, 16'h0100, 16'h0000, 16'h0000, 16'h0001, 16'h0100);
  endtask

  task automatic test_descending();
    send_triple(16'h0500, 16'h0100, 16'h0200, 16'hfe00, 16'hfb00, 16'h0300);
    send_triple(16'h7fff, 16'h0000, 16'h8000, 16'h0000, 16'h0100, 16'h0000);
    send_triple(16'h0027, 16'h0ff0, 16'h0013, 16'hf00f, 16'h0000, 16'h0001);
  endtask

  task automatic test_random(int count);
    logic [15:0] v[6];
    for (int i = 0; i < count; i++) begin
      foreach (v[j]) v[j] = 16'($urandom);
      case ($urandom_range(9))
        0: v[2] = v[0];
        1: v[4] = v[2];
        2: v[4] = v[0];
        3: begin
          // Small neighborhood sweeps exercise the x rounding near the ends.
          v[2] = v[0] + 16'($urandom_range(60, 1));
          v[4] = v[2] + 16'($urandom_range(60, 1));
        end
        default: ;
      endcase
      send_triple(v[0], v[1], v[2], v[3], v[4], v[5]);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 36; recv_idle_pct = 67;
    test_degenerate();
    test_extremes();
    test_descending();
    test_random(100);
    send_idle_pct = 67; recv_idle_pct = 36;
    test_random(110);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(107);
    s_axis_tvalid <= 1'b0;
    while (fit_points_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/qfp_pkg.sv
hw/rtl/qfp_front.sv
hw/rtl/qfp_fifo.sv
hw/rtl/qfp_back.sv
hw/rtl/quadratic_fit_point_generator_top.sv
verif/tb.sv
